// ===== rtl/comment_string_aware_brace_scanner_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Brace scanner assertion macros
// Shared concurrent assertion forms for the brace scanner checkers.
// ----------------------------------------------------------------------------
`ifndef COMMENT_STRING_AWARE_BRACE_SCANNER_UNIT_DEFINES_SVH
`define COMMENT_STRING_AWARE_BRACE_SCANNER_UNIT_DEFINES_SVH

// Checked on every rising edge of clk outside reset.
`define CSBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define CSBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/csbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Brace scanner package
// Item types, character codes, lexical modes and the per-byte step function.
// ----------------------------------------------------------------------------
package csbs_pkg;

  localparam int DEPTH_BITS  = 16;
  localparam int OUT_DEPTH_W = 16;

  typedef logic signed [DEPTH_BITS:0] depth_t;
  typedef logic [OUT_DEPTH_W-1:0]     brace_depth_t;

  localparam depth_t DEPTH_MAX = {1'b0, {DEPTH_BITS{1'b1}}};
  localparam depth_t DEPTH_MIN = {1'b1, {DEPTH_BITS{1'b0}}};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [5:0] {
    MODE_CODE  = 6'b000001,
    MODE_LINE  = 6'b000010,
    MODE_BLOCK = 6'b000100,
    MODE_STR   = 6'b001000,
    MODE_CHR   = 6'b010000,
    MODE_TEXT  = 6'b100000
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  skip;
    depth_t      depth;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{mode: MODE_CODE, skip: 2'd0, depth: '0};

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic         open_text_block;
    logic         open_comment;
    brace_depth_t open_brace_depth;
  } out_item_t;

  // Decide one byte c given the byte after it (nx) and whether c starts a
  // triple quote; a pending skip consumes the byte instead.
  function automatic lex_state_t head_step(lex_state_t st, logic [7:0] c,
                                           logic [7:0] nx, logic tq);
    lex_state_t n;
    n = st;
    if (st.skip != 2'd0) begin
      n.skip = st.skip - 2'd1;
    end else begin
      case (st.mode)
        MODE_LINE: begin
          if (c == CH_NL) n.mode = MODE_CODE;
        end
        MODE_BLOCK: begin
          if (c == CH_STAR && nx == CH_SLASH) begin
            n.mode = MODE_CODE;
            n.skip = 2'd1;
          end
        end
        MODE_TEXT: begin
          if (c == CH_BSLASH) begin
            n.skip = 2'd1;
          end else if (tq) begin
            n.mode = MODE_CODE;
            n.skip = 2'd2;
          end
        end
        MODE_STR: begin
          if (c == CH_BSLASH) n.skip = 2'd1;
          else if (c == CH_QUOTE || c == CH_NL) n.mode = MODE_CODE;
        end
        MODE_CHR: begin
          if (c == CH_BSLASH) n.skip = 2'd1;
          else if (c == CH_APOS || c == CH_NL) n.mode = MODE_CODE;
        end
        default: begin
          if (c == CH_SLASH && nx == CH_SLASH) begin
            n.mode = MODE_LINE;
            n.skip = 2'd1;
          end else if (c == CH_SLASH && nx == CH_STAR) begin
            n.mode = MODE_BLOCK;
            n.skip = 2'd1;
          end else if (tq) begin
            n.mode = MODE_TEXT;
            n.skip = 2'd2;
          end else if (c == CH_QUOTE) begin
            n.mode = MODE_STR;
          end else if (c == CH_APOS) begin
            n.mode = MODE_CHR;
          end else if (c == CH_LBRACE) begin
            if (st.depth != DEPTH_MAX) n.depth = st.depth + depth_t'(1);
          end else if (c == CH_RBRACE) begin
            if (st.depth != DEPTH_MIN) n.depth = st.depth - depth_t'(1);
          end
        end
      endcase
    end
    return n;
  endfunction

endpackage

// ===== rtl/csbs_lex.sv =====
// ----------------------------------------------------------------------------
// Brace scanner lexer core
// Holds the lexical state and the two-byte lookahead buffer, and advances
// them by one byte per step. On the last byte the buffer is drained and the
// summary is formed.
// ----------------------------------------------------------------------------
module csbs_lex (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  csbs_pkg::in_item_t  item,
  output csbs_pkg::out_item_t result
);

  csbs_pkg::lex_state_t st;
  csbs_pkg::lex_state_t st_next;
  logic [7:0]           buf0;
  logic [7:0]           buf1;
  logic [7:0]           buf0_next;
  logic [7:0]           buf1_next;
  logic [1:0]           fill;
  logic [1:0]           fill_next;

  logic [7:0]           w0, w1, w2;
  logic [1:0]           cnt;
  logic                 triple;
  csbs_pkg::lex_state_t s1, s2, s3, s_end;

  // Window of held bytes followed by the incoming byte.
  always_comb begin
    case (fill)
      2'd0: begin
        w0  = item.char_code;
        w1  = csbs_pkg::CH_NUL;
        w2  = csbs_pkg::CH_NUL;
        cnt = 2'd1;
      end
      2'd1: begin
        w0  = buf0;
        w1  = item.char_code;
        w2  = csbs_pkg::CH_NUL;
        cnt = 2'd2;
      end
      default: begin
        w0  = buf0;
        w1  = buf1;
        w2  = item.char_code;
        cnt = 2'd3;
      end
    endcase
  end

  assign triple = (cnt == 2'd3) && (w0 == csbs_pkg::CH_QUOTE) &&
                  (w1 == csbs_pkg::CH_QUOTE) && (w2 == csbs_pkg::CH_QUOTE);

  // Bytes past the end of the window read as zero, so only the first
  // position can ever see a full triple quote during the drain.
  always_comb begin
    s1 = csbs_pkg::head_step(st, w0, (cnt == 2'd1) ? csbs_pkg::CH_NUL : w1, triple);
    s2 = csbs_pkg::head_step(s1, w1, (cnt == 2'd3) ? w2 : csbs_pkg::CH_NUL, 1'b0);
    s3 = csbs_pkg::head_step(s2, w2, csbs_pkg::CH_NUL, 1'b0);
    case (cnt)
      2'd1:    s_end = s1;
      2'd2:    s_end = s2;
      default: s_end = s3;
    endcase
  end

  always_comb begin
    result.open_text_block = (s_end.mode == csbs_pkg::MODE_TEXT);
    result.open_comment    = (s_end.mode == csbs_pkg::MODE_BLOCK);
    if (!s_end.depth[csbs_pkg::DEPTH_BITS] && (s_end.depth != '0)) begin
      result.open_brace_depth =
        csbs_pkg::brace_depth_t'(s_end.depth[csbs_pkg::DEPTH_BITS-1:0]);
    end else begin
      result.open_brace_depth = '0;
    end
  end

  always_comb begin
    st_next   = st;
    buf0_next = w0;
    buf1_next = w1;
    fill_next = cnt;
    if (item.is_last) begin
      st_next   = csbs_pkg::LEX_RESET;
      fill_next = 2'd0;
    end else if (cnt == 2'd3) begin
      st_next   = s1;
      buf0_next = w1;
      buf1_next = w2;
      fill_next = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= csbs_pkg::LEX_RESET;
      fill <= 2'd0;
    end else if (step) begin
      st   <= st_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      buf0 <= buf0_next;
      buf1 <= buf1_next;
    end
  end

endmodule

// ===== rtl/comment_string_aware_brace_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// Comment and string aware brace scanner
// Scans source text one byte per item and reports, on the last byte, whether
// the text ended inside a text block or a block comment and how many braces
// are still open.
//
//   channel | direction | payload    | handshake
//   in      | input     | in_item_t  | in_valid / in_stall
//   out     | output    | out_item_t | out_valid / out_stall
//
// One item per cycle is taken while no last item waits on a stalled result.
// The result is registered when its last item steps the lexer core.
// Items that are not last give no result and never wait on the out channel.
// A last item waits in the input register only while the previous result is
// stalled.
// Reset is synchronous and clears the lexical state and both valid flags.
// ----------------------------------------------------------------------------
module comment_string_aware_brace_scanner_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  csbs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output csbs_pkg::out_item_t out_data
);

  logic                in_vld;
  csbs_pkg::in_item_t  in_reg;
  logic                out_vld;
  csbs_pkg::out_item_t out_reg;
  csbs_pkg::out_item_t result;
  logic                out_free;
  logic                adv;
  logic                accept;

  assign out_free = !out_vld || !out_stall;
  assign adv      = in_vld && (!in_reg.is_last || out_free);
  assign in_stall = in_vld && !adv;
  assign accept   = in_valid && !in_stall;

  csbs_lex u_lex (
    .clk    (clk),
    .rst    (rst),
    .step   (adv),
    .item   (in_reg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv && in_reg.is_last) begin
      out_vld <= 1'b1;
    end else if (!out_stall) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_reg.is_last) begin
      out_reg <= result;
    end
  end

  assign out_valid = out_vld;
  assign out_data  = out_reg;

endmodule

// ===== rtl/csbs_checker.sv =====
// ----------------------------------------------------------------------------
// Brace scanner port checker
// Watches the top-level ports and checks handshake and result timing.
// ----------------------------------------------------------------------------
`include "comment_string_aware_brace_scanner_unit_defines.svh"

module csbs_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input csbs_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input csbs_pkg::out_item_t out_data
);

  `CSBS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "out item dropped while stalled")
  `CSBS_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data), "out item changed while stalled")
  `CSBS_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && !in_stall, "block not idle after reset")
  `CSBS_ASSERT(a_result_from_last, $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.is_last, 2), "result without a last item")

endmodule

bind comment_string_aware_brace_scanner_unit csbs_checker u_csbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/comment_string_aware_brace_scanner_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Brace scanner testbench
// Sends texts of one byte per item through the scanner. Every accepted byte
// also goes through a scanner written here. That copy tracks the lexical mode,
// the pending skip, the two held bytes and the brace depth. Its report at the
// end of each text is compared with the one the block returns. Short hand-made
// texts come first, then random texts built from comments, strings, character
// literals, text blocks, braces and noise. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module comment_string_aware_brace_scanner_unit_test;

  localparam int RANDOM_BYTES = 1900;
  localparam int MAX_GAP      = 13;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int SAT_SPAN     = 1 << csbs_pkg::DEPTH_BITS;
  localparam int DEPTH_TOP    = SAT_SPAN - 1;
  localparam int DEPTH_BOTTOM = -SAT_SPAN;

  typedef struct {
    csbs_pkg::in_item_t item;
    int unsigned        gap;
  } byte_slot_t;

  typedef enum {
    FRAG_BRACE,
    FRAG_LINE_COMMENT,
    FRAG_BLOCK_COMMENT,
    FRAG_STRING,
    FRAG_CHAR,
    FRAG_TEXT_BLOCK,
    FRAG_ESCAPE,
    FRAG_NOISE
  } fragment_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  csbs_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  csbs_pkg::out_item_t out_data;

  byte_slot_t          byte_queue[$];
  csbs_pkg::out_item_t expected_reports[$];
  logic [7:0]          text_buf[$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         idle_left      = 0;
  int unsigned         stall_left     = 0;

  // Scanner state of the checking copy.
  csbs_pkg::mode_t scan_mode  = csbs_pkg::MODE_CODE;
  int unsigned     scan_skip  = 0;
  logic [7:0]      scan_buf[0:2];
  int unsigned     scan_fill  = 0;
  int              scan_depth = 0;

  comment_string_aware_brace_scanner_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  function void clear_scanner();
    scan_mode  = csbs_pkg::MODE_CODE;
    scan_skip  = 0;
    scan_buf[0] = csbs_pkg::CH_NUL;
    scan_buf[1] = csbs_pkg::CH_NUL;
    scan_buf[2] = csbs_pkg::CH_NUL;
    scan_fill  = 0;
    scan_depth = 0;
  endfunction

  // Decides the oldest held byte from itself and the bytes behind it, then
  // drops it. Positions past the end of the text read as zero bytes.
  function void settle_head();
    logic [7:0] c;
    logic [7:0] nx;
    logic       triple;
    c      = scan_buf[0];
    nx     = (scan_fill >= 2) ? scan_buf[1] : csbs_pkg::CH_NUL;
    triple = (scan_fill >= 3) && c == csbs_pkg::CH_QUOTE && nx == csbs_pkg::CH_QUOTE &&
             scan_buf[2] == csbs_pkg::CH_QUOTE;
    if (scan_skip != 0) begin
      scan_skip--;
    end else begin
      case (scan_mode)
        csbs_pkg::MODE_LINE: begin
          if (c == csbs_pkg::CH_NL) scan_mode = csbs_pkg::MODE_CODE;
        end
        csbs_pkg::MODE_BLOCK: begin
          if (c == csbs_pkg::CH_STAR && nx == csbs_pkg::CH_SLASH) begin
            scan_mode = csbs_pkg::MODE_CODE;
            scan_skip = 1;
          end
        end
        csbs_pkg::MODE_TEXT: begin
          if (c == csbs_pkg::CH_BSLASH) begin
            scan_skip = 1;
          end else if (triple) begin
            scan_mode = csbs_pkg::MODE_CODE;
            scan_skip = 2;
          end
        end
        csbs_pkg::MODE_STR: begin
          if (c == csbs_pkg::CH_BSLASH) scan_skip = 1;
          else if (c == csbs_pkg::CH_QUOTE || c == csbs_pkg::CH_NL)
            scan_mode = csbs_pkg::MODE_CODE;
        end
        csbs_pkg::MODE_CHR: begin
          if (c == csbs_pkg::CH_BSLASH) scan_skip = 1;
          else if (c == csbs_pkg::CH_APOS || c == csbs_pkg::CH_NL)
            scan_mode = csbs_pkg::MODE_CODE;
        end
        default: begin
          if (c == csbs_pkg::CH_SLASH && nx == csbs_pkg::CH_SLASH) begin
            scan_mode = csbs_pkg::MODE_LINE;
            scan_skip = 1;
          end else if (c == csbs_pkg::CH_SLASH && nx == csbs_pkg::CH_STAR) begin
            scan_mode = csbs_pkg::MODE_BLOCK;
            scan_skip = 1;
          end else if (triple) begin
            scan_mode = csbs_pkg::MODE_TEXT;
            scan_skip = 2;
          end else if (c == csbs_pkg::CH_QUOTE) begin
            scan_mode = csbs_pkg::MODE_STR;
          end else if (c == csbs_pkg::CH_APOS) begin
            scan_mode = csbs_pkg::MODE_CHR;
          end else if (c == csbs_pkg::CH_LBRACE) begin
            if (scan_depth < DEPTH_TOP) scan_depth++;
          end else if (c == csbs_pkg::CH_RBRACE) begin
            if (scan_depth > DEPTH_BOTTOM) scan_depth--;
          end
        end
      endcase
    end
    scan_buf[0] = scan_buf[1];
    scan_buf[1] = scan_buf[2];
    scan_buf[2] = csbs_pkg::CH_NUL;
    scan_fill--;
  endfunction

  function void scan_byte(csbs_pkg::in_item_t it);
    csbs_pkg::out_item_t report;
    scan_buf[scan_fill] = it.char_code;
    scan_fill++;
    if (!it.is_last) begin
      if (scan_fill == 3) settle_head();
    end else begin
      while (scan_fill > 0) settle_head();
      report.open_text_block  = (scan_mode == csbs_pkg::MODE_TEXT);
      report.open_comment     = (scan_mode == csbs_pkg::MODE_BLOCK);
      report.open_brace_depth =
        (scan_depth > 0) ? csbs_pkg::brace_depth_t'(scan_depth) : '0;
      expected_reports.push_back(report);
      clear_scanner();
    end
  endfunction

  // Content bytes lean toward braces, zero and the bytes that change the lexical mode.
  function logic [7:0] pick_content();
    case ($urandom_range(0, 15))
      0: return csbs_pkg::CH_LBRACE;
      1: return csbs_pkg::CH_RBRACE;
      2: return csbs_pkg::CH_QUOTE;
      3: return csbs_pkg::CH_APOS;
      4: return csbs_pkg::CH_SLASH;
      5: return csbs_pkg::CH_STAR;
      6: return csbs_pkg::CH_BSLASH;
      7: return csbs_pkg::CH_NL;
      8: return csbs_pkg::CH_NUL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function void add_content(int unsigned n);
    repeat (n) text_buf.push_back(pick_content());
  endfunction

  function void add_string(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function void add_fragment();
    int unsigned n;
    fragment_t   kind;
    n    = $urandom_range(0, 4);
    kind = fragment_t'($urandom_range(0, FRAG_NOISE));
    case (kind)
      FRAG_BRACE: begin
        text_buf.push_back(($urandom_range(0, 2) != 0) ? csbs_pkg::CH_LBRACE :
                                                         csbs_pkg::CH_RBRACE);
      end
      FRAG_LINE_COMMENT: begin
        add_string("//");
        add_content(n);
        text_buf.push_back(csbs_pkg::CH_NL);
      end
      FRAG_BLOCK_COMMENT: begin
        add_string("/*");
        add_content(n);
        add_string("*/");
      end
      FRAG_STRING: begin
        text_buf.push_back(csbs_pkg::CH_QUOTE);
        add_content(n);
        text_buf.push_back(csbs_pkg::CH_QUOTE);
      end
      FRAG_CHAR: begin
        text_buf.push_back(csbs_pkg::CH_APOS);
        add_content(n);
        text_buf.push_back(csbs_pkg::CH_APOS);
      end
      FRAG_TEXT_BLOCK: begin
        add_string("\"\"\"");
        add_content(n);
        add_string("\"\"\"");
      end
      FRAG_ESCAPE: begin
        text_buf.push_back(($urandom_range(0, 1) != 0) ? csbs_pkg::CH_QUOTE :
                                                         csbs_pkg::CH_APOS);
        text_buf.push_back(csbs_pkg::CH_BSLASH);
        add_content(n);
        text_buf.push_back(csbs_pkg::CH_QUOTE);
      end
      default: begin
        add_content(n + 1);
      end
    endcase
  endfunction

  // Moves the text under construction into the send queue, marking its final
  // byte. Some texts go out with no gaps at all.
  function void queue_text(bit no_gaps);
    byte_slot_t slot;
    bit         calm;
    calm = no_gaps || ($urandom_range(0, 4) == 0);
    while (text_buf.size() > 0) begin
      slot.item.char_code = text_buf.pop_front();
      slot.item.is_last   = (text_buf.size() == 0);
      slot.gap            = calm ? 0 : $urandom_range(0, MAX_GAP);
      byte_queue.push_back(slot);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    byte_slot_t slot;
    logic       next_valid;
    if (rst) begin
      in_valid  <= 1'b0;
      idle_left = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        scan_byte(in_data);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (byte_queue.size() > 0) begin
          slot = byte_queue.pop_front();
          in_data   <= slot.item;
          next_valid = 1'b1;
          idle_left  = slot.gap;
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(posedge clk) begin
    csbs_pkg::out_item_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with nothing expected", out_data.open_brace_depth, 0);
        end else begin
          want = expected_reports.pop_front();
          if (out_data.open_text_block !== want.open_text_block)
            report_mismatch("open_text_block", out_data.open_text_block,
                            want.open_text_block);
          if (out_data.open_comment !== want.open_comment)
            report_mismatch("open_comment", out_data.open_comment, want.open_comment);
          if (out_data.open_brace_depth !== want.open_brace_depth)
            report_mismatch("open_brace_depth", out_data.open_brace_depth,
                            want.open_brace_depth);
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    string       directed_texts[$];
    int unsigned random_bytes;
    int unsigned target;

    clear_scanner();

    // A lone zero byte, then a high byte and a zero byte around a brace.
    text_buf.push_back(csbs_pkg::CH_NUL);
    queue_text(0);
    text_buf.push_back(8'hFF);
    text_buf.push_back(csbs_pkg::CH_LBRACE);
    text_buf.push_back(csbs_pkg::CH_NUL);
    queue_text(0);

    // Flush with a full buffer, negative depth, each comment, escapes in
    // strings and character literals, newline ending a literal, text blocks
    // closed and left open, a skip running past the end and a lone slash.
    directed_texts = '{"{{{", "}}{", "//{\n{", "/*{*/{", "/*{", "\"\\\"{\"{",
                       "'\\''{", "'\n{", "\"\"\"{\"\"\"{", "\"\"\"", "\"\\", "/"};
    foreach (directed_texts[i]) begin
      add_string(directed_texts[i]);
      queue_text(0);
    end

    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      while (text_buf.size() < target) add_fragment();
      random_bytes += text_buf.size();
      queue_text(0);
    end

    while (rst) @(posedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/csbs_pkg.sv
rtl/csbs_lex.sv
rtl/comment_string_aware_brace_scanner_unit.sv
rtl/csbs_checker.sv
dv/comment_string_aware_brace_scanner_unit_test.sv
